@@ rtl/mvfr_pkg.sv @@
// Shared types and defaults for the minmod vertical face reconstruction block.
// No dependencies; used by every module of the block.
package mvfr_pkg;

   localparam int MAX_ROW_LENGTH_DEFAULT = 1024;
   localparam int SAMPLE_WIDTH_DEFAULT   = 32;
   localparam int ROW_LENGTH_WIDTH       = 11;

   // Per-sample control that travels alongside the data
   typedef struct packed {
      logic row_last;   // last column of its row
      logic emit;       // a result is produced for this sample
   } sample_tag_type;

endpackage

@@ rtl/minmod_vertical_face_reconstruct.sv @@
// Minmod-limited vertical face reconstruction over a raster stream (top level).
// Path to rsp_: line buffer register, datapath stages 2 to 5, then output register.
// Throughput: one transaction per cycle unless rsp_ stalls; set by the line buffer's
// single read-modify-write per column (one read and one write port, forwarded).
// Reset: counters, pipeline valids and row_length (to MAX_ROW_LENGTH, at most 2047) cleared;
// the line buffer memory is not cleared and needs no clearing pass.
// Depends on mvfr_pkg, mvfr_raster_ctrl, mvfr_line_buffer, mvfr_face_datapath.
module minmod_vertical_face_reconstruct #(
   parameter int MAX_ROW_LENGTH = mvfr_pkg::MAX_ROW_LENGTH_DEFAULT,
   parameter int SAMPLE_WIDTH   = mvfr_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // input sample stream
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // tdata: height_sample, surface_sample (then zero fill to whole bytes)
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,
   // tuser: frame_start
   input  logic                                       req_tuser,
   // result stream
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // tdata: face_value (then zero fill to whole bytes)
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // tlast: row_end
   output logic                                       rsp_tlast,
   // row_length register write
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [mvfr_pkg::ROW_LENGTH_WIDTH-1:0]      csr_data
);

   localparam int AW    = $clog2(MAX_ROW_LENGTH);
   localparam int SW    = SAMPLE_WIDTH;
   localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   logic                     advance, accept;
   logic [AW-1:0]            column;
   mvfr_pkg::sample_tag_type tag, s1_tag;
   logic                     s1_valid;
   logic [SW-1:0]            s1_new_h, s1_new_z, s1_mid_h, s1_mid_z, s1_old_h, s1_old_z;
   logic [SW-1:0]            face;

   // The whole pipeline moves whenever the output register is free or being
   // drained; a waiting result only holds things up while it is stalled.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // Column/row tracking: frame_start restarts counts, first two rows only fill
   mvfr_raster_ctrl #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .accept      (accept),
      .frame_start (req_tuser),
      .column      (column),
      .tag         (tag)
   );

   // Previous and older rows share one memory word per column; each sample
   // reads its column and writes back {previous, new} once the pipeline advances.
   mvfr_line_buffer #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH)
   ) u_lbuf (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .accept         (accept),
      .column         (column),
      .tag            (tag),
      .new_height     (req_tdata[SW-1:0]),
      .new_surface    (req_tdata[2*SW-1:SW]),
      .s1_valid       (s1_valid),
      .s1_tag         (s1_tag),
      .s1_new_height  (s1_new_h),
      .s1_new_surface (s1_new_z),
      .s1_mid_height  (s1_mid_h),
      .s1_mid_surface (s1_mid_z),
      .s1_old_height  (s1_old_h),
      .s1_old_surface (s1_old_z)
   );

   // Slopes, minmod limiting, halving and saturation over five stages
   mvfr_face_datapath #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .s1_valid       (s1_valid),
      .s1_tag         (s1_tag),
      .s1_new_height  (s1_new_h),
      .s1_new_surface (s1_new_z),
      .s1_mid_height  (s1_mid_h),
      .s1_mid_surface (s1_mid_z),
      .s1_old_height  (s1_old_h),
      .s1_old_surface (s1_old_z),
      .out_valid      (rsp_tvalid),
      .out_face       (face),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'(face);

endmodule

@@ rtl/mvfr_raster_ctrl.sv @@
// Raster position tracking and row length register.
// Depends on mvfr_pkg.
module mvfr_raster_ctrl #(
   parameter int MAX_ROW_LENGTH = mvfr_pkg::MAX_ROW_LENGTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mvfr_pkg::ROW_LENGTH_WIDTH-1:0]  csr_data,
   input  logic                                   accept,
   input  logic                                   frame_start,
   output logic [$clog2(MAX_ROW_LENGTH)-1:0]      column,
   output mvfr_pkg::sample_tag_type               tag
);

   localparam int AW   = $clog2(MAX_ROW_LENGTH);
   localparam int LW   = $clog2(MAX_ROW_LENGTH + 1);
   localparam int RLW  = mvfr_pkg::ROW_LENGTH_WIDTH;
   localparam int CW   = (LW > RLW) ? LW : RLW;
   localparam int RLMAX = (1 << RLW) - 1;
   localparam int RST_LEN = (MAX_ROW_LENGTH > RLMAX) ? RLMAX : MAX_ROW_LENGTH;

   logic [RLW-1:0] row_length_ff;
   logic [AW-1:0]  column_ff, column_in;
   logic [1:0]     rows_ff, rows_in;
   logic [CW-1:0]  len_raw, len_eff, col_base, col_sel;
   logic [1:0]     rows_base;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= RLW'(RST_LEN);
      end else if (csr_valid) begin
         row_length_ff <= csr_data;
      end
   end

   always_comb begin
      len_raw = CW'(row_length_ff);
      if (len_raw == '0) begin
         len_eff = CW'(1);
      end else if (len_raw > CW'(MAX_ROW_LENGTH)) begin
         len_eff = CW'(MAX_ROW_LENGTH);
      end else begin
         len_eff = len_raw;
      end
      col_base  = frame_start ? '0 : CW'(column_ff);
      rows_base = frame_start ? 2'd0 : rows_ff;
      // length shrunk mid-row: clamp onto the last column
      col_sel = (col_base >= len_eff) ? (len_eff - CW'(1)) : col_base;
      column  = col_sel[AW-1:0];
      tag.row_last = ((col_sel + CW'(1)) >= len_eff);
      tag.emit     = (rows_base == 2'd2);
      if (tag.row_last) begin
         column_in = '0;
         rows_in   = (rows_base == 2'd2) ? rows_base : rows_base + 2'd1;
      end else begin
         column_in = column + AW'(1);
         rows_in   = rows_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         rows_ff   <= 2'd0;
      end else if (accept) begin
         column_ff <= column_in;
         rows_ff   <= rows_in;
      end
   end

endmodule

@@ rtl/mvfr_line_buffer.sv @@
// Two-row line buffer held in one synchronous memory, read-modify-write per column.
// Depends on mvfr_pkg.
module mvfr_line_buffer #(
   parameter int MAX_ROW_LENGTH = mvfr_pkg::MAX_ROW_LENGTH_DEFAULT,
   parameter int SAMPLE_WIDTH   = mvfr_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              accept,
   input  logic [$clog2(MAX_ROW_LENGTH)-1:0] column,
   input  mvfr_pkg::sample_tag_type          tag,
   input  logic [SAMPLE_WIDTH-1:0]           new_height,
   input  logic [SAMPLE_WIDTH-1:0]           new_surface,
   output logic                              s1_valid,
   output mvfr_pkg::sample_tag_type          s1_tag,
   output logic [SAMPLE_WIDTH-1:0]           s1_new_height,
   output logic [SAMPLE_WIDTH-1:0]           s1_new_surface,
   output logic [SAMPLE_WIDTH-1:0]           s1_mid_height,
   output logic [SAMPLE_WIDTH-1:0]           s1_mid_surface,
   output logic [SAMPLE_WIDTH-1:0]           s1_old_height,
   output logic [SAMPLE_WIDTH-1:0]           s1_old_surface
);

   localparam int AW = $clog2(MAX_ROW_LENGTH);
   localparam int SW = SAMPLE_WIDTH;
   localparam int EW = 4 * SW;

   // entry: {older z, older h, previous z, previous h}
   logic [EW-1:0] mem [MAX_ROW_LENGTH];

   logic                     valid_ff;
   mvfr_pkg::sample_tag_type tag_ff;
   logic [AW-1:0]            column_ff;
   logic [SW-1:0]            height_ff, surface_ff;
   logic [EW-1:0]            rd_ff, fwd_data_ff;
   logic                     fwd_ff, fwd_in;
   logic [EW-1:0]            entry, wr_data;

   assign entry   = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data = {entry[2*SW-1:0], surface_ff, height_ff};
   // write of the item leaving now lands after this edge's read
   assign fwd_in  = valid_ff && (column_ff == column);

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[column];
      end
      if (advance && valid_ff) begin
         mem[column_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
         column_ff   <= column;
         tag_ff      <= tag;
         height_ff   <= new_height;
         surface_ff  <= new_surface;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= accept;
      end
   end

   assign s1_valid       = valid_ff;
   assign s1_tag         = tag_ff;
   assign s1_new_height  = height_ff;
   assign s1_new_surface = surface_ff;
   assign s1_mid_height  = entry[SW-1:0];
   assign s1_mid_surface = entry[2*SW-1:SW];
   assign s1_old_height  = entry[3*SW-1:2*SW];
   assign s1_old_surface = entry[4*SW-1:3*SW];

endmodule

@@ rtl/mvfr_face_datapath.sv @@
// Pipelined minmod slope limiter and face value arithmetic with output register.
// Depends on mvfr_pkg.
module mvfr_face_datapath #(
   parameter int SAMPLE_WIDTH = mvfr_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     s1_valid,
   input  mvfr_pkg::sample_tag_type s1_tag,
   input  logic [SAMPLE_WIDTH-1:0]  s1_new_height,
   input  logic [SAMPLE_WIDTH-1:0]  s1_new_surface,
   input  logic [SAMPLE_WIDTH-1:0]  s1_mid_height,
   input  logic [SAMPLE_WIDTH-1:0]  s1_mid_surface,
   input  logic [SAMPLE_WIDTH-1:0]  s1_old_height,
   input  logic [SAMPLE_WIDTH-1:0]  s1_old_surface,
   output logic                     out_valid,
   output logic [SAMPLE_WIDTH-1:0]  out_face,
   output logic                     out_last
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int D1 = SW + 1;   // differences
   localparam int D2 = SW + 2;   // sums of differences
   localparam int D3 = SW + 3;   // minmod difference
   localparam int D4 = SW + 4;   // doubled face value

   // stage 2: vertical differences
   logic                 v2_ff;
   logic                 l2_ff;
   logic signed [D1-1:0] dh1_ff, dz1_ff, dh2_ff, dz2_ff;
   logic [SW-1:0]        z2_ff;
   // stage 3: slope sums, minmod of h slopes
   logic                 v3_ff, l3_ff;
   logic signed [D2-1:0] a3_ff, b3_ff;
   logic signed [D1-1:0] m2_3_ff, m2_in;
   logic [SW-1:0]        z3_ff;
   // stage 4: minmod of z+h slopes
   logic                 v4_ff, l4_ff;
   logic signed [D2-1:0] m1_4_ff, m1_in;
   logic signed [D1-1:0] m2_4_ff;
   logic [SW-1:0]        z4_ff;
   // stage 5: limiter difference
   logic                 v5_ff, l5_ff;
   logic signed [D3-1:0] diff5_ff;
   logic [SW-1:0]        z5_ff;
   // output
   logic                 valid_ff, last_ff;
   logic [SW-1:0]        face_ff, face_in;
   logic signed [D4-1:0] twice;
   logic [D3-1:0]        halved;

   function automatic logic signed [D1-1:0] ext1(input logic [SW-1:0] x);
      ext1 = {x[SW-1], x};
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         l2_ff  <= s1_tag.row_last;
         dh1_ff <= ext1(s1_mid_height) - ext1(s1_new_height);
         dz1_ff <= ext1(s1_mid_surface) - ext1(s1_new_surface);
         dh2_ff <= ext1(s1_old_height) - ext1(s1_mid_height);
         dz2_ff <= ext1(s1_old_surface) - ext1(s1_mid_surface);
         z2_ff  <= s1_mid_surface;
      end
   end

   always_comb begin
      if (!dh1_ff[D1-1] && !dh2_ff[D1-1]) begin
         m2_in = (dh1_ff <= dh2_ff) ? dh1_ff : dh2_ff;
      end else if (dh1_ff[D1-1] && dh2_ff[D1-1]) begin
         m2_in = (dh1_ff >= dh2_ff) ? dh1_ff : dh2_ff;
      end else begin
         m2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l3_ff   <= l2_ff;
         a3_ff   <= {dz1_ff[D1-1], dz1_ff} + {dh1_ff[D1-1], dh1_ff};
         b3_ff   <= {dz2_ff[D1-1], dz2_ff} + {dh2_ff[D1-1], dh2_ff};
         m2_3_ff <= m2_in;
         z3_ff   <= z2_ff;
      end
   end

   // zero counts as non-negative, and every arm then gives zero
   always_comb begin
      if (!a3_ff[D2-1] && !b3_ff[D2-1]) begin
         m1_in = (a3_ff <= b3_ff) ? a3_ff : b3_ff;
      end else if (a3_ff[D2-1] && b3_ff[D2-1]) begin
         m1_in = (a3_ff >= b3_ff) ? a3_ff : b3_ff;
      end else begin
         m1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l4_ff   <= l3_ff;
         m1_4_ff <= m1_in;
         m2_4_ff <= m2_3_ff;
         z4_ff   <= z3_ff;
         l5_ff    <= l4_ff;
         diff5_ff <= {m1_4_ff[D2-1], m1_4_ff} - {{2{m2_4_ff[D1-1]}}, m2_4_ff};
         z5_ff    <= z4_ff;
      end
   end

   // floor((2z - diff) / 2), then clamp to the sample range
   always_comb begin
      twice  = {{3{z5_ff[SW-1]}}, z5_ff, 1'b0} - {diff5_ff[D3-1], diff5_ff};
      halved = twice[D4-1:1];
      if (halved[D3-1:SW-1] == '0 || halved[D3-1:SW-1] == '1) begin
         face_in = halved[SW-1:0];
      end else if (!halved[D3-1]) begin
         face_in = {1'b0, {(SW-1){1'b1}}};
      end else begin
         face_in = {1'b1, {(SW-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         face_ff <= face_in;
         last_ff <= l5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         v2_ff    <= s1_valid && s1_tag.emit;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         valid_ff <= v5_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_face  = face_ff;
   assign out_last  = last_ff;

endmodule

@@ rtl/mvfr_checker.sv @@
// Port-level checks for minmod_vertical_face_reconstruct, bound to the top level.
// Depends on mvfr_pkg and the top level's ports.
module mvfr_checker #(
   parameter int SAMPLE_WIDTH = mvfr_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   input logic                                rsp_tlast
);

   // input back-pressure only comes from a stalled result
   a_ready_only_when_stalled : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled result");

   a_reset_clears_result : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   a_result_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result payload changed while stalled");

endmodule

bind minmod_vertical_face_reconstruct mvfr_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mvfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
